// File: sv/mfe_pkg.sv
// Shared types, constants and register codes of the multitap feedback echo.
package mfe_pkg;

    // Delay line depth; must be a power of two so the pointers wrap naturally.
    localparam int DelayDepth = 16384;
    localparam int PtrW       = $clog2(DelayDepth);
    localparam int TapCount   = 5;
    localparam int TapW       = (TapCount > 1) ? $clog2(TapCount) : 1;
    localparam int NumGains   = 5;

    localparam int SampleW  = 16;
    localparam int GainW    = 15;
    localparam int SpacingW = 12;
    localparam int ProdW    = SampleW + GainW + 1;
    // input * 2^15 plus five products, each below 2^30 in magnitude
    localparam int AccW     = SampleW + GainW + 3;
    localparam int QW       = AccW - GainW;

    localparam int DataW   = 32;
    localparam int AddrW   = 5;
    localparam int RegIdxW = AddrW - 2;

    localparam logic [RegIdxW-1:0] RegSpacing   = 3'd0;
    localparam logic [RegIdxW-1:0] RegGainOne   = 3'd1;
    localparam logic [RegIdxW-1:0] RegGainTwo   = 3'd2;
    localparam logic [RegIdxW-1:0] RegGainThree = 3'd3;
    localparam logic [RegIdxW-1:0] RegGainFour  = 3'd4;
    localparam logic [RegIdxW-1:0] RegGainFive  = 3'd5;

    localparam logic [SpacingW-1:0] SpacingReset = 12'd1600;
    localparam logic [NumGains-1:0][GainW-1:0] GainReset =
        {15'd3277, 15'd6554, 15'd9830, 15'd16384, 15'd22938};

    localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
    localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;
    localparam logic [AccW-1:0] RoundBias = AccW'((1 << GainW) - 1);

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic [PtrW-1:0]           t_ptr;

    typedef struct packed {
        logic [SpacingW-1:0]              spacing;
        logic [NumGains-1:0][GainW-1:0]   gains;
    } t_cfg;

    typedef struct packed {
        logic            start;
        logic            rd_valid;
        logic [TapW-1:0] rd_tap;
        logic            rd_ok;
        logic            rd_last;
        logic            round;
    } t_mac_ctl;

endpackage

// File: sv/mfe_in_if.sv
// Input sample channel.
interface mfe_in_if import mfe_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// File: sv/mfe_out_if.sv
// Result sample channel.
interface mfe_out_if import mfe_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample echo_sample;
    logic    clipped;

    modport source (output valid, output echo_sample, output clipped, input ready);
    modport sink   (input valid, input echo_sample, input clipped, output ready);
endinterface

// File: sv/mfe_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module mfe_ram #(
    parameter int Depth = 1024,
    parameter int Width = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mfe_regs.sv
// APB configuration registers: tap spacing and the five tap gains.
module mfe_regs import mfe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg               r_cfg;
    logic               w_wr;
    logic [RegIdxW-1:0] w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[AddrW-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing <= SpacingReset;
            r_cfg.gains   <= GainReset;
        end else if (w_wr) begin
            case (w_idx)
                RegSpacing:   r_cfg.spacing  <= pwdata[SpacingW-1:0];
                RegGainOne:   r_cfg.gains[0] <= pwdata[GainW-1:0];
                RegGainTwo:   r_cfg.gains[1] <= pwdata[GainW-1:0];
                RegGainThree: r_cfg.gains[2] <= pwdata[GainW-1:0];
                RegGainFour:  r_cfg.gains[3] <= pwdata[GainW-1:0];
                RegGainFive:  r_cfg.gains[4] <= pwdata[GainW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            RegSpacing:   prdata = DataW'(r_cfg.spacing);
            RegGainOne:   prdata = DataW'(r_cfg.gains[0]);
            RegGainTwo:   prdata = DataW'(r_cfg.gains[1]);
            RegGainThree: prdata = DataW'(r_cfg.gains[2]);
            RegGainFour:  prdata = DataW'(r_cfg.gains[3]);
            RegGainFive:  prdata = DataW'(r_cfg.gains[4]);
            default:      prdata = '0;
        endcase
    end

endmodule

// File: sv/mfe_mac.sv
// Tap multiply-accumulate, round toward zero and 16-bit saturation.
module mfe_mac import mfe_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_mac_ctl                        i_ctl,
    input  t_sample                         i_in_sample,
    input  t_sample                         i_rdata,
    input  logic [NumGains-1:0][GainW-1:0]  i_gains,
    output logic                            o_done,
    output t_sample                         o_sample,
    output logic                            o_clip
);

    logic                    r_c_valid;
    logic                    r_c_last;
    logic signed [ProdW-1:0] r_c_prod;
    logic signed [AccW-1:0]  r_acc;
    logic signed [QW-1:0]    r_q;

    logic [GainW-1:0]        w_gain;
    t_sample                 w_tap;
    logic signed [ProdW-1:0] w_prod;
    logic [AccW-1:0]         w_biased;

    assign w_gain = i_gains[i_ctl.rd_tap];
    // an entry not yet written since reset reads as silence
    assign w_tap  = i_ctl.rd_ok ? i_rdata : '0;
    assign w_prod = $signed({1'b0, w_gain}) * w_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_c_last  <= 1'b0;
        end else begin
            r_c_valid <= i_ctl.rd_valid;
            r_c_last  <= i_ctl.rd_valid && i_ctl.rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_valid) begin
            r_c_prod <= w_prod;
        end
        if (i_ctl.start) begin
            r_acc <= {{(AccW - SampleW - GainW){i_in_sample[SampleW-1]}},
                      i_in_sample, {GainW{1'b0}}};
        end else if (r_c_valid) begin
            r_acc <= r_acc + AccW'(r_c_prod);
        end
        if (i_ctl.round) begin
            r_q <= $signed(w_biased[AccW-1:GainW]);
        end
    end

    assign o_done = r_c_valid && r_c_last;

    // negative sums get 2^15-1 added so the shift truncates toward zero
    assign w_biased = r_acc[AccW-1] ? (r_acc + RoundBias) : r_acc;

    always_comb begin
        if (r_q > SampleMax) begin
            o_sample = SampleMax;
            o_clip   = 1'b1;
        end else if (r_q < SampleMin) begin
            o_sample = SampleMin;
            o_clip   = 1'b1;
        end else begin
            o_sample = r_q[SampleW-1:0];
            o_clip   = 1'b0;
        end
    end

endmodule

// File: sv/multitap_feedback_echo.sv
// Five-tap feedback echo: each sample plus five Q15-weighted past outputs spaced k*tap_spacing
// back, truncated toward zero and saturated, with the result fed back into a 16384-entry RAM.
// Each item steps through: the accept, five reads on the single RAM read port, multiply and
// accumulate, rounding and the writeback; no new sample is taken before that writeback. The
// result sits in an output register, so the next sample is taken while it waits; writeback
// stalls only if the previous result is still not taken. There is no clearing pass after
// reset: a fill mark tracks which entries were written, and unwritten ones read zero.
module multitap_feedback_echo import mfe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mfe_in_if.sink           i_in,
    mfe_out_if.source        o_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StRun   = 3'd1;
    localparam logic [2:0] StDrain = 3'd2;
    localparam logic [2:0] StRound = 3'd3;
    localparam logic [2:0] StWrite = 3'd4;

    t_cfg      w_cfg;
    t_mac_ctl  w_ctl;

    logic [2:0]      r_state, n_state;
    t_ptr            r_wp;
    logic            r_wrapped;
    t_ptr            r_raddr;
    logic [TapW-1:0] r_tap;
    logic            r_rd_valid;
    logic [TapW-1:0] r_rd_tap;
    logic            r_rd_ok;
    logic            r_rd_last;
    logic            r_out_valid;
    t_sample         r_echo_sample;
    logic            r_out_clip;

    logic    w_accept;
    logic    w_issue;
    logic    w_tap_last;
    logic    w_store;
    t_ptr    w_step;
    t_sample w_rdata;
    t_sample w_sum;
    logic    w_clip;
    logic    w_done;

    mfe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_issue    = (r_state == StRun);
    assign w_tap_last = (r_tap == TapW'(TapCount - 1));
    assign w_store    = (r_state == StWrite) && (!r_out_valid || o_out.ready);
    assign w_step     = PtrW'(w_cfg.spacing);

    assign i_in.ready = (r_state == StIdle);

    // item's writeback always lands before the next item's first read
    mfe_ram #(
        .Depth (DelayDepth),
        .Width (SampleW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_wp),
        .i_wdata (w_sum),
        .i_re    (w_issue),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_ctl.start    = w_accept;
        w_ctl.rd_valid = r_rd_valid;
        w_ctl.rd_tap   = r_rd_tap;
        w_ctl.rd_ok    = r_rd_ok;
        w_ctl.rd_last  = r_rd_last;
        w_ctl.round    = (r_state == StRound);
    end

    mfe_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_in_sample (i_in.in_sample),
        .i_rdata     (w_rdata),
        .i_gains     (w_cfg.gains),
        .o_done      (w_done),
        .o_sample    (w_sum),
        .o_clip      (w_clip)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle:  if (w_accept) n_state = StRun;
            StRun:   if (w_tap_last) n_state = StDrain;
            StDrain: if (w_done) n_state = StRound;
            StRound: n_state = StWrite;
            StWrite: if (w_store) n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_issue;
            if (w_store) begin
                r_wp <= r_wp + 1'b1;
                if (r_wp == '1) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (w_store) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raddr <= r_wp - w_step;
            r_tap   <= '0;
        end else if (w_issue) begin
            r_raddr <= r_raddr - w_step;
            r_tap   <= r_tap + 1'b1;
        end
        if (w_issue) begin
            r_rd_tap  <= r_tap;
            r_rd_ok   <= r_wrapped || (r_raddr < r_wp);
            r_rd_last <= w_tap_last;
        end
        if (w_store) begin
            r_echo_sample <= w_sum;
            r_out_clip    <= w_clip;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.echo_sample = r_echo_sample;
    assign o_out.clipped     = r_out_clip;

endmodule

// File: sv/mfe_chk.sv
// Port-level checks of the echo block, bound to the top level.
module mfe_chk import mfe_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_echo_sample,
    input logic    i_clipped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again while a sample is in work");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clipped |-> i_echo_sample == SampleMax || i_echo_sample == SampleMin)
        else $error("clipped flag on an unsaturated sample");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind multitap_feedback_echo mfe_chk u_mfe_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_echo_sample (o_out.echo_sample),
    .i_clipped     (o_out.clipped)
);

// File: verif/multitap_feedback_echo_tb.sv
// Self-checking testbench for the multitap feedback echo: directed table, then random phases.
module multitap_feedback_echo_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mfe_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int HoldCycles  = 300;
    localparam int DrainCycles = 16;
    localparam int NumPhases   = 8;
    localparam int PhaseItems  = 200;
    localparam int ReportMax   = 10;

    // addresses past the last register; writes there must be ignored
    localparam logic [RegIdxW-1:0] RegBadSix   = 3'd6;
    localparam logic [RegIdxW-1:0] RegBadSeven = 3'd7;

    typedef struct {
        t_sample smp;
        logic    clip;
    } t_echo_beat;

    typedef struct {
        bit                  is_cfg;
        logic [RegIdxW-1:0]  idx;
        logic [DataW-1:0]    data;
        t_sample             smp;
        bit                  typed;
        t_sample             exp_smp;
        logic                exp_clip;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    mfe_in_if  in_ch ();
    mfe_out_if out_ch ();

    multitap_feedback_echo i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // echo model state
    t_sample             echo_line [DelayDepth];
    t_ptr                echo_wptr;
    logic [SpacingW-1:0] cfg_spacing;
    logic [GainW-1:0]    cfg_gain [NumGains];

    t_echo_beat pending_echo [$];
    int         fail_count = 0;
    int         cycle_cnt  = 0;

    bit          gap_on      = 1'b0;
    int          burst_left  = 0;
    bit          rx_stall_on = 1'b0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    logic [12:0] rx_pat      = 13'h1B5D;
    int          rx_turn     = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= ReportMax) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    function automatic t_echo_beat echo_predict(input t_sample x);
        logic signed [47:0] acc;
        logic signed [47:0] quo;
        t_ptr               delay;
        int                 k;
        t_echo_beat         r;
        acc = x * 48'sd32768;
        for (k = 1; k <= TapCount; k++) begin
            // power-of-two depth: truncation to the pointer width is the wrap
            delay = t_ptr'(k * cfg_spacing);
            acc = acc + $signed({1'b0, cfg_gain[k-1]}) * echo_line[t_ptr'(echo_wptr - delay)];
        end
        quo = acc / 48'sd32768;
        r.clip = 1'b0;
        if (quo > 48'sd32767) begin
            r.smp  = SampleMax;
            r.clip = 1'b1;
        end else if (quo < -48'sd32768) begin
            r.smp  = SampleMin;
            r.clip = 1'b1;
        end else begin
            r.smp = t_sample'(quo);
        end
        echo_line[echo_wptr] = r.smp;
        echo_wptr = echo_wptr + 1'b1;
        return r;
    endfunction

    function automatic void apply_cfg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] d);
        case (idx)
            RegSpacing:   cfg_spacing = d[SpacingW-1:0];
            RegGainOne:   cfg_gain[0] = d[GainW-1:0];
            RegGainTwo:   cfg_gain[1] = d[GainW-1:0];
            RegGainThree: cfg_gain[2] = d[GainW-1:0];
            RegGainFour:  cfg_gain[3] = d[GainW-1:0];
            RegGainFive:  cfg_gain[4] = d[GainW-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [DataW-1:0] reg_image(input logic [RegIdxW-1:0] idx);
        case (idx)
            RegSpacing:   return DataW'(cfg_spacing);
            RegGainOne:   return DataW'(cfg_gain[0]);
            RegGainTwo:   return DataW'(cfg_gain[1]);
            RegGainThree: return DataW'(cfg_gain[2]);
            RegGainFour:  return DataW'(cfg_gain[3]);
            RegGainFive:  return DataW'(cfg_gain[4]);
            default:      return '0;
        endcase
    endfunction

    // APB tasks are entered and left at a falling edge
    task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] d);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = d;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_reg(input logic [RegIdxW-1:0] idx);
        logic [DataW-1:0] rd;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== reg_image(idx)) begin
            note_fail($sformatf("reg %0d read: expected %0h, got %0h", idx, reg_image(idx), rd));
        end
    endtask

    task automatic cfg_set(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] d);
        apb_write(idx, d);
        apply_cfg(idx, d);
        if (idx <= RegGainFive) begin
            check_reg(idx);
        end
    endtask

    // wait for every expected beat, then let the last writeback land
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending_echo.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_sample(input t_sample s, input bit typed, input t_sample es,
                               input logic ec);
        t_echo_beat want;
        if (gap_on && burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid     = 1'b1;
        in_ch.in_sample = s;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        want = echo_predict(s);
        if (typed) begin
            want.smp  = es;
            want.clip = ec;
        end
        pending_echo.push_back(want);
        if (burst_left != 0) begin
            burst_left--;
        end
        @(negedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 7))
            0:       return SampleMax;
            1:       return SampleMin;
            2, 3:    return t_sample'($urandom);
            default: return t_sample'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [DataW-1:0] rand_spacing();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return 32'd3276;
            4:       return DataW'($urandom_range(1, 8));
            default: return DataW'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [DataW-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return DataW'($urandom_range(0, 7000));
        endcase
    endfunction

    function automatic t_plan_row cfg_row(input logic [RegIdxW-1:0] idx,
                                          input logic [DataW-1:0] d);
        t_plan_row r;
        r = '{is_cfg: 1'b1, idx: idx, data: d, smp: '0, typed: 1'b0, exp_smp: '0, exp_clip: 1'b0};
        return r;
    endfunction

    function automatic t_plan_row smp_row(input t_sample s);
        t_plan_row r;
        r = '{is_cfg: 1'b0, idx: '0, data: '0, smp: s, typed: 1'b0, exp_smp: '0, exp_clip: 1'b0};
        return r;
    endfunction

    function automatic t_plan_row known_row(input t_sample s, input t_sample es, input logic ec);
        t_plan_row r;
        r = '{is_cfg: 1'b0, idx: '0, data: '0, smp: s, typed: 1'b1, exp_smp: es, exp_clip: ec};
        return r;
    endfunction

    // receiver: stall pattern, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req     = 1'b0;
            hold_left    = HoldCycles - 1;
            out_ch.ready = 1'b0;
        end else if (rx_stall_on) begin
            out_ch.ready = rx_pat[0];
            rx_pat       = {rx_pat[0], rx_pat[12:1]};
            rx_turn++;
            if (rx_turn == 39) begin
                rx_turn = 0;
                rx_pat  = $urandom_range(0, 1) ? 13'($urandom | $urandom)
                                               : 13'($urandom & $urandom);
                if (rx_pat == '0) begin
                    rx_pat = 13'h1;
                end
            end
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_echo_beat want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_echo.size() == 0) begin
                note_fail($sformatf("unexpected beat: sample %0d clipped %b",
                                    out_ch.echo_sample, out_ch.clipped));
            end else begin
                want = pending_echo.pop_front();
                if (out_ch.echo_sample !== want.smp) begin
                    note_fail($sformatf("echo_sample: expected %0d, got %0d",
                                        want.smp, out_ch.echo_sample));
                end
                if (out_ch.clipped !== want.clip) begin
                    note_fail($sformatf("clipped: expected %b, got %b",
                                        want.clip, out_ch.clipped));
                end
            end
        end
    end

    initial begin
        t_plan_row plan [$];
        int        ph;
        int        ri;

        in_ch.valid     = 1'b0;
        in_ch.in_sample = '0;
        out_ch.ready    = 1'b1;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_rst_n         = 1'b0;

        foreach (echo_line[i]) echo_line[i] = '0;
        echo_wptr   = '0;
        cfg_spacing = SpacingReset;
        for (ri = 0; ri < NumGains; ri++) cfg_gain[ri] = GainReset[ri];

        // fresh line: every tap reads zero, so each sample comes straight through
        plan.push_back(known_row(16'sd0, 16'sd0, 1'b0));
        plan.push_back(known_row(SampleMax, SampleMax, 1'b0));
        plan.push_back(known_row(16'sh5555, 16'sh5555, 1'b0));
        plan.push_back(known_row(16'shAAAA, 16'shAAAA, 1'b0));
        plan.push_back(known_row(-16'sd1, -16'sd1, 1'b0));
        plan.push_back(known_row(SampleMin, SampleMin, 1'b0));
        // full gains, spacing 1: upper bits of the writes must be dropped
        plan.push_back(cfg_row(RegSpacing, 32'hFFFF_F001));
        plan.push_back(cfg_row(RegGainOne, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(RegGainTwo, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(RegGainThree, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(RegGainFour, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(RegGainFive, 32'hFFFF_FFFF));
        // negative saturation
        plan.push_back(smp_row(SampleMin));
        plan.push_back(smp_row(SampleMin));
        plan.push_back(smp_row(SampleMax));
        // zero spacing: taps read the not yet written entry under the pointer
        plan.push_back(cfg_row(RegSpacing, 32'd0));
        repeat (5) plan.push_back(known_row(SampleMax, SampleMax, 1'b0));
        // positive saturation off a line full of maxima
        plan.push_back(cfg_row(RegSpacing, 32'd1));
        plan.push_back(smp_row(SampleMax));
        plan.push_back(smp_row(SampleMin));
        plan.push_back(cfg_row(RegBadSix, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(RegBadSeven, 32'd0));
        // k * spacing past the depth wraps around
        plan.push_back(cfg_row(RegSpacing, 32'h0000_0FFF));
        plan.push_back(smp_row(16'sh1234));
        plan.push_back(smp_row(-16'sh1234));
        plan.push_back(cfg_row(RegSpacing, 32'd3276));
        plan.push_back(smp_row(16'sd100));
        // zero gains: pure pass-through
        plan.push_back(cfg_row(RegGainOne, 32'd0));
        plan.push_back(cfg_row(RegGainTwo, 32'd0));
        plan.push_back(cfg_row(RegGainThree, 32'd0));
        plan.push_back(cfg_row(RegGainFour, 32'd0));
        plan.push_back(cfg_row(RegGainFive, 32'd0));
        plan.push_back(cfg_row(RegSpacing, DataW'(SpacingReset)));
        plan.push_back(known_row(SampleMin, SampleMin, 1'b0));
        plan.push_back(known_row(SampleMax, SampleMax, 1'b0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (ri = int'(RegSpacing); ri <= int'(RegGainFive); ri++) begin
            check_reg(RegIdxW'(ri));
        end

        gap_on      = 1'b1;
        rx_stall_on = 1'b1;
        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                settle();
                cfg_set(plan[n].idx, plan[n].data);
            end else begin
                send_sample(plan[n].smp, plan[n].typed, plan[n].exp_smp, plan[n].exp_clip);
            end
        end

        for (ph = 0; ph < NumPhases; ph++) begin
            settle();
            for (ri = int'(RegSpacing); ri <= int'(RegGainFive); ri++) begin
                if (ph == 0 || $urandom_range(0, 3) != 0) begin
                    cfg_set(RegIdxW'(ri), (ri == int'(RegSpacing)) ? rand_spacing() : rand_gain());
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                cfg_set($urandom_range(0, 1) ? RegBadSix : RegBadSeven, $urandom);
            end
            gap_on      = (ph == 1) || (ph >= 4 && $urandom_range(0, 1) == 1);
            rx_stall_on = (ph == 2) || (ph >= 4 && $urandom_range(0, 2) != 0);
            burst_left  = 0;
            // sender keeps offering while the receiver holds off, so the input backs up
            if (ph == 3) begin
                hold_req = 1'b1;
            end
            repeat (PhaseItems) send_sample(rand_sample(), 1'b0, '0, 1'b0);
        end

        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/mfe_pkg.sv
sv/mfe_in_if.sv
sv/mfe_out_if.sv
sv/mfe_ram.sv
sv/mfe_regs.sv
sv/mfe_mac.sv
sv/multitap_feedback_echo.sv
sv/mfe_chk.sv
verif/multitap_feedback_echo_tb.sv
